// ===== hw/rtl/rtpfp_pkg.sv =====
// shared types and constants for the lossless rtp frame packer
// no dependencies; imported by every module of the block
`default_nettype none

package rtpfp_pkg;

  // sample pairs in one frame, and the pair counter width
  localparam int FRAME_SAMPLES = 352;
  localparam int PAIR_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

  // front-to-back queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQUENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RTP_TIME = 2'd2;

  // fixed header bytes
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] RTP_TYPE_FIRST   = 8'he0;
  localparam logic [7:0] RTP_TYPE_NEXT    = 8'h60;
  localparam logic [7:0] FRAME_HDR_BYTE0  = 8'h20;
  localparam logic [7:0] FRAME_HDR_BYTE1  = 8'h00;
  localparam logic [6:0] FRAME_HDR_CARRY  = 7'h01;

  // one classified sample pair as it travels from front to back
  typedef struct packed {
    logic [15:0] left_sample;
    logic [15:0] right_sample;
    logic        first;
    logic        last;
  } pair_item_t;

  // configuration register contents
  typedef struct packed {
    logic [31:0] source_id;
    logic [15:0] initial_sequence;
    logic [31:0] initial_rtp_time;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtpfp_front.sv =====
// front end: accepts sample pairs and tags frame start and frame end
// depends on rtpfp_pkg
`default_nettype none

module rtpfp_front
  import rtpfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic [15:0] in_left_sample,
  input  wire logic [15:0] in_right_sample,
  input  wire logic        q_full,
  output pair_item_t       q_item,
  output logic             q_push
);

  logic [PAIR_W-1:0] pair_r, pair_nxt;
  logic              is_first, is_last;

  // position of this pair within its frame
  assign is_first = (pair_r == '0);
  assign is_last  = (pair_r == PAIR_W'(FRAME_SAMPLES - 1));

  assign q_push = in_push && !q_full;

  always_comb begin
    q_item.left_sample  = in_left_sample;
    q_item.right_sample = in_right_sample;
    q_item.first        = is_first;
    q_item.last         = is_last;
  end

  // pair counter wraps at the end of each frame
  always_comb begin
    pair_nxt = pair_r;
    if (q_push) begin
      pair_nxt = is_last ? '0 : pair_r + PAIR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= '0;
    end else begin
      pair_r <= pair_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rtpfp_fifo.sv =====
// short queue of classified pairs between front and back
// depends on rtpfp_pkg
`default_nettype none

module rtpfp_fifo
  import rtpfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire pair_item_t push_item,
  output logic       full,
  input  wire logic pop,
  output pair_item_t head_item,
  output logic       head_valid
);

  pair_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rtpfp_back.sv =====
// back end: byte sequencer for rtp header, frame header and packed samples
// depends on rtpfp_pkg
`default_nettype none

module rtpfp_back
  import rtpfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire pair_item_t  head_item,
  input  wire logic        head_valid,
  output logic             head_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_byte,
  output logic             out_packet_end
);

  // byte positions within one item's output
  localparam logic [4:0] STEP_VER      = 5'd0;
  localparam logic [4:0] STEP_TYPE     = 5'd1;
  localparam logic [4:0] STEP_SEQ_HI   = 5'd2;
  localparam logic [4:0] STEP_SEQ_LO   = 5'd3;
  localparam logic [4:0] STEP_TS_3     = 5'd4;
  localparam logic [4:0] STEP_TS_2     = 5'd5;
  localparam logic [4:0] STEP_TS_1     = 5'd6;
  localparam logic [4:0] STEP_TS_0     = 5'd7;
  localparam logic [4:0] STEP_SID_3    = 5'd8;
  localparam logic [4:0] STEP_SID_2    = 5'd9;
  localparam logic [4:0] STEP_SID_1    = 5'd10;
  localparam logic [4:0] STEP_SID_0    = 5'd11;
  localparam logic [4:0] STEP_FHDR_0   = 5'd12;
  localparam logic [4:0] STEP_FHDR_1   = 5'd13;
  localparam logic [4:0] STEP_PAY_0    = 5'd14;
  localparam logic [4:0] STEP_PAY_1    = 5'd15;
  localparam logic [4:0] STEP_PAY_2    = 5'd16;
  localparam logic [4:0] STEP_PAY_3    = 5'd17;
  localparam logic [4:0] STEP_END      = 5'd18;

  logic [4:0]  step_r, step_nxt, cur_step;
  logic        active_r, active_nxt;
  logic [6:0]  carry_r, carry_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic        first_pkt_r, first_pkt_nxt;
  logic        loaded_r, loaded_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_end_r, out_end_nxt;
  logic        advance, emit, item_done;
  logic [15:0] eff_seq;
  logic [31:0] eff_ts;
  logic [7:0]  byte_val;

  // output register moves when empty or when its byte is taken
  assign advance = !out_valid_r || out_pop;
  assign emit    = head_valid && advance;

  // an item starts either at the packet header or straight at its payload
  assign cur_step = active_r ? step_r : (head_item.first ? STEP_VER : STEP_PAY_0);

  assign item_done = emit &&
                     ((cur_step == STEP_PAY_3 && !head_item.last) || cur_step == STEP_END);
  assign head_pop  = item_done;

  // start values come from configuration until the first packet has begun
  assign eff_seq = loaded_r ? seq_r : cfg.initial_sequence;
  assign eff_ts  = loaded_r ? ts_r  : cfg.initial_rtp_time;

  // byte selection for the current step
  always_comb begin
    case (cur_step)
      STEP_VER:    byte_val = RTP_VERSION_BYTE;
      STEP_TYPE:   byte_val = first_pkt_r ? RTP_TYPE_FIRST : RTP_TYPE_NEXT;
      STEP_SEQ_HI: byte_val = seq_r[15:8];
      STEP_SEQ_LO: byte_val = seq_r[7:0];
      STEP_TS_3:   byte_val = ts_r[31:24];
      STEP_TS_2:   byte_val = ts_r[23:16];
      STEP_TS_1:   byte_val = ts_r[15:8];
      STEP_TS_0:   byte_val = ts_r[7:0];
      STEP_SID_3:  byte_val = cfg.source_id[31:24];
      STEP_SID_2:  byte_val = cfg.source_id[23:16];
      STEP_SID_1:  byte_val = cfg.source_id[15:8];
      STEP_SID_0:  byte_val = cfg.source_id[7:0];
      STEP_FHDR_0: byte_val = FRAME_HDR_BYTE0;
      STEP_FHDR_1: byte_val = FRAME_HDR_BYTE1;
      STEP_PAY_0:  byte_val = {carry_r, head_item.left_sample[15]};
      STEP_PAY_1:  byte_val = {head_item.left_sample[14:8], head_item.left_sample[7]};
      STEP_PAY_2:  byte_val = {head_item.left_sample[6:0], head_item.right_sample[15]};
      STEP_PAY_3:  byte_val = {head_item.right_sample[14:8], head_item.right_sample[7]};
      STEP_END:    byte_val = {carry_r, 1'b0};
      default:     byte_val = 8'h00;
    endcase
  end

  // sequencer and packet state
  always_comb begin
    step_nxt      = step_r;
    active_nxt    = active_r;
    carry_nxt     = carry_r;
    seq_nxt       = seq_r;
    ts_nxt        = ts_r;
    first_pkt_nxt = first_pkt_r;
    loaded_nxt    = loaded_r;
    if (emit) begin
      if (item_done) begin
        active_nxt = 1'b0;
      end else begin
        active_nxt = 1'b1;
        step_nxt   = cur_step + 5'd1;
      end
      case (cur_step)
        STEP_VER: begin
          seq_nxt    = eff_seq;
          ts_nxt     = eff_ts;
          loaded_nxt = 1'b1;
        end
        STEP_TYPE:   first_pkt_nxt = 1'b0;
        STEP_FHDR_1: carry_nxt = FRAME_HDR_CARRY;
        STEP_PAY_3:  carry_nxt = head_item.right_sample[6:0];
        STEP_END: begin
          carry_nxt = '0;
          seq_nxt   = seq_r + 16'd1;
          ts_nxt    = ts_r + 32'(FRAME_SAMPLES);
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = byte_val;
      out_end_nxt   = (cur_step == STEP_END);
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_VER;
      active_r    <= 1'b0;
      carry_r     <= '0;
      seq_r       <= '0;
      ts_r        <= '0;
      first_pkt_r <= 1'b1;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      active_r    <= active_nxt;
      carry_r     <= carry_nxt;
      seq_r       <= seq_nxt;
      ts_r        <= ts_nxt;
      first_pkt_r <= first_pkt_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_packet_end = out_end_r;

  // checks on the sequencer
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (step_r <= STEP_END))
    else $error("sequencer step out of range");

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> head_valid)
    else $error("queue head lost while an item is in progress");

  a_end_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_byte_r[0] == 1'b0))
    else $error("packet end byte carries a set pad bit");

  a_end_after_pay: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cur_step == STEP_END) |-> (active_r && head_item.last))
    else $error("end byte emitted outside the last pair of a frame");

endmodule

`default_nettype wire

// ===== hw/rtl/rtp_lossless_frame_packer.sv =====
// Lossless-audio RTP frame packer. Takes one stereo pair of 16-bit samples
// per request on a queue-style input (push/full) and delivers the packet one
// byte per request on a queue-style output (empty/pop). The first pair of a
// frame is preceded by a 12-byte RTP header and two frame-header bytes; the
// last pair of a frame is followed by one end byte flagged by
// out_packet_end. The back end puts out one byte per cycle while bytes are
// popped and pairs are queued; a pair yields 4 bytes, 18 when it opens a
// frame and one more when it closes one: about 4.04 bytes per pair in a frame.
// A four-entry queue lets the front accept pairs while the back end is still
// sending a header. Configuration is taken at any time by cfg_valid (always
// ready) and should be written only while the block is idle.
// depends on rtpfp_pkg, rtpfp_front, rtpfp_fifo, rtpfp_back
`default_nettype none

module rtp_lossless_frame_packer
  import rtpfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [15:0]          in_left_sample,
  input  wire logic [15:0]          in_right_sample,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [7:0]                out_byte,
  output logic                      out_packet_end,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  pair_item_t front_item, head_item;
  logic       q_push, q_full, q_pop, head_valid;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SOURCE_ID:        cfg_nxt.source_id        = cfg_data;
        CFG_INITIAL_SEQUENCE: cfg_nxt.initial_sequence = cfg_data[15:0];
        CFG_INITIAL_RTP_TIME: cfg_nxt.initial_rtp_time = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;

  rtpfp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .q_full          (q_full),
    .q_item          (front_item),
    .q_push          (q_push)
  );

  rtpfp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_item  (head_item),
    .head_valid (head_valid)
  );

  rtpfp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head_item      (head_item),
    .head_valid     (head_valid),
    .head_pop       (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end)
  );

endmodule

`default_nettype wire

// ===== dv/rtpfp_tb_pkg.sv =====
// scoreboard for the lossless rtp frame packer testbench: byte predictor and checker
// depends on rtpfp_pkg for the frame length and the register index codes

package rtpfp_tb_pkg;
  import rtpfp_pkg::*;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // fixed bytes of the packet and frame headers
  localparam logic [7:0] HDR_VERSION     = 8'h80;
  localparam logic [7:0] HDR_MARKER_TYPE = 8'he0;
  localparam logic [7:0] HDR_PLAIN_TYPE  = 8'h60;
  localparam logic [7:0] HDR_CHANNELS    = 8'h20;
  localparam logic [7:0] HDR_ZERO        = 8'h00;
  localparam logic [6:0] HDR_TAIL_BITS   = 7'h01;

  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packet_byte_t;

  class packet_byte_scoreboard;
    // register copies
    logic [31:0] source_id;
    logic [15:0] start_sequence;
    logic [31:0] start_stamp;
    // packer state
    logic [15:0] sequence_num;
    logic [31:0] stamp;
    int unsigned pairs_in_frame;
    logic [6:0]  carry_bits;
    bit          first_packet;
    bit          start_taken;
    // bytes still to come, oldest first
    packet_byte_t due_bytes[$];
    // run statistics
    int unsigned mismatches;
    int unsigned pairs_noted;
    int unsigned bytes_checked;
    int unsigned packets_closed;
    int unsigned headers_built;

    function new();
      source_id      = '0;
      start_sequence = '0;
      start_stamp    = '0;
      sequence_num   = '0;
      stamp          = '0;
      pairs_in_frame = 0;
      carry_bits     = '0;
      first_packet   = 1'b1;
      start_taken    = 1'b0;
      mismatches     = 0;
      pairs_noted    = 0;
      bytes_checked  = 0;
      packets_closed = 0;
      headers_built  = 0;
    endfunction

    function int unsigned outstanding();
      return due_bytes.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SOURCE_ID:        source_id = data;
        CFG_INITIAL_SEQUENCE: start_sequence = data[15:0];
        CFG_INITIAL_RTP_TIME: start_stamp = data;
        default: ;
      endcase
    endfunction

    function void add_byte(logic [7:0] data, logic last);
      packet_byte_t b;
      b.data = data;
      b.last = last;
      due_bytes.push_back(b);
    endfunction

    // payload byte goes out shifted through the 7-bit carry
    function void pack_payload_byte(logic [7:0] b);
      add_byte({carry_bits, b[7]}, 1'b0);
      carry_bits = b[6:0];
    endfunction

    // one accepted sample pair: work out every byte it causes
    function void note_pair(logic [15:0] left, logic [15:0] right);
      pairs_noted++;
      if (pairs_in_frame == 0) begin
        // start values are taken once, on the first pair after reset
        if (!start_taken) begin
          sequence_num = start_sequence;
          stamp        = start_stamp;
          start_taken  = 1'b1;
        end
        add_byte(HDR_VERSION, 1'b0);
        add_byte(first_packet ? HDR_MARKER_TYPE : HDR_PLAIN_TYPE, 1'b0);
        first_packet = 1'b0;
        add_byte(sequence_num[15:8], 1'b0);
        add_byte(sequence_num[7:0], 1'b0);
        for (int i = 3; i >= 0; i--) add_byte(stamp[8*i +: 8], 1'b0);
        for (int i = 3; i >= 0; i--) add_byte(source_id[8*i +: 8], 1'b0);
        add_byte(HDR_CHANNELS, 1'b0);
        add_byte(HDR_ZERO, 1'b0);
        carry_bits = HDR_TAIL_BITS;
        headers_built++;
      end
      pack_payload_byte(left[15:8]);
      pack_payload_byte(left[7:0]);
      pack_payload_byte(right[15:8]);
      pack_payload_byte(right[7:0]);
      pairs_in_frame++;
      // frame full: flush the carry and advance the counters
      if (pairs_in_frame >= FRAME_SAMPLES) begin
        add_byte({carry_bits, 1'b0}, 1'b1);
        carry_bits     = '0;
        pairs_in_frame = 0;
        sequence_num   = sequence_num + 16'd1;
        stamp          = stamp + 32'(FRAME_SAMPLES);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH: %0s", msg);
    endtask

    task check_byte(logic [7:0] data, logic last);
      packet_byte_t want;
      if (due_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h end %0b with nothing due", data, last));
        return;
      end
      want = due_bytes.pop_front();
      bytes_checked++;
      if (data !== want.data)
        report_mismatch($sformatf("byte %0d: data %02h, want %02h", bytes_checked, data,
                                  want.data));
      if (last !== want.last)
        report_mismatch($sformatf("byte %0d: end %0b, want %0b", bytes_checked, last,
                                  want.last));
      if (want.last) packets_closed++;
    endtask

    task check_drained();
      if (due_bytes.size() != 0)
        report_mismatch($sformatf("%0d bytes never delivered", due_bytes.size()));
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
// top-level testbench for rtp_lossless_frame_packer: drives sample pairs and
// register writes, checks every delivered byte against packet_byte_scoreboard
// depends on rtpfp_pkg, rtpfp_tb_pkg and the packer rtl

module tb_top;
  import rtpfp_pkg::*;
  import rtpfp_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT      = 3000;
  localparam int LONG_HOLD_CYCLES = 250;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [15:0]          in_left_sample;
  logic [15:0]          in_right_sample;
  logic                 out_empty;
  logic                 out_pop;
  logic [7:0]           out_byte;
  logic                 out_packet_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // idling controls: tx for the input side, rx and the long hold for the output side
  bit tx_idle_en;
  bit rx_idle_en;
  int long_hold_req;

  packet_byte_scoreboard sb = new();

  // extremes, single bits and alternating patterns
  logic [31:0] directed_pairs [0:11] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h8000_0001, 32'h0001_8000,
    32'h7fff_fffe, 32'hfffe_7fff, 32'haaaa_5555, 32'h5555_aaaa,
    32'h00ff_ff00, 32'hff00_00ff, 32'h0080_0100, 32'hffff_0000
  };

  rtp_lossless_frame_packer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_packet_end  (out_packet_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // sample values weighted towards the extremes
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // register write; valid stays high when another write follows
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  // offer one pair until taken, then maybe idle for a burst
  task automatic send_pair(logic [15:0] left, logic [15:0] right);
    in_push         <= 1'b1;
    in_left_sample  <= left;
    in_right_sample <= right;
    do @(posedge clk); while (in_full);
    sb.note_pair(left, right);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pair(pick_sample(), pick_sample());
  endtask

  // stop offering and wait for every due byte, then a short tail
  task automatic drain_results(int unsigned tail);
    in_push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // output side: pops with random stalls and one long hold on request
  initial begin : pop_side
    int unsigned stall_left;
    int          holds_seen;
    stall_left = 0;
    holds_seen = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_byte(out_byte, out_packet_end);
      if (long_hold_req != holds_seen) begin
        holds_seen = long_hold_req;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any request taken
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst_n           <= 1'b0;
    in_push         <= 1'b0;
    in_left_sample  <= '0;
    in_right_sample <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_SOURCE_ID;
    cfg_data        <= '0;
    rx_idle_en      <= 1'b1;
    long_hold_req   <= 0;
    tx_idle_en      = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // start values near wrap so the second packet shows both counters wrapping
    write_reg(CFG_SOURCE_ID, 32'hffff_ffff, 1'b0);
    write_reg(CFG_INITIAL_SEQUENCE, 32'hbeef_ffff, 1'b0);
    write_reg(CFG_INITIAL_RTP_TIME, 32'hffff_ff00, 1'b0);
    write_reg(CFG_UNMAPPED, 32'hdead_beef, 1'b1);

    // directed pairs, first packet of the run
    foreach (directed_pairs[i]) send_pair(directed_pairs[i][31:16], directed_pairs[i][15:0]);
    drain_results(4);

    // source id change inside a frame, late start values are ignored
    write_reg(CFG_SOURCE_ID, 32'h0000_0000, 1'b0);
    write_reg(CFG_INITIAL_SEQUENCE, 32'h0000_0000, 1'b0);
    write_reg(CFG_INITIAL_RTP_TIME, 32'h0000_0000, 1'b1);
    send_random(150);
    drain_results(4);

    // output held off for a long stretch while pairs keep coming; frame closes here
    write_reg(CFG_SOURCE_ID, $urandom, 1'b0);
    write_reg(CFG_UNMAPPED, $urandom, 1'b1);
    tx_idle_en = 1'b0;
    long_hold_req <= long_hold_req + 1;
    send_random(200);
    drain_results(4);

    // full speed on both sides to the end
    write_reg(CFG_SOURCE_ID, 32'h8000_0001, 1'b0);
    write_reg(CFG_INITIAL_SEQUENCE, $urandom, 1'b1);
    rx_idle_en <= 1'b0;
    send_random(90);
    drain_results(40);
    sb.check_drained();

    $display("pairs %0d, bytes checked %0d, headers %0d, packets closed %0d, mismatches %0d",
             sb.pairs_noted, sb.bytes_checked, sb.headers_built, sb.packets_closed,
             sb.mismatches);
    $display("covered start-value load, counter wrap, mid-frame source id change, ",
             "unmapped register write and a long output hold");
    if (sb.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
